// ----- design/clustered_dot_halftone_cell_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the clustered-dot halftone cell unit
// Short forms for clocked assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef CLUSTERED_DOT_HALFTONE_CELL_UNIT_MACROS_SVH
`define CLUSTERED_DOT_HALFTONE_CELL_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge of clk.
`define CDH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge of clk.
`define CDH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cdh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clustered-dot halftone package
// Shared widths, the dot-gain band tables, the threshold ROM and the types
// that connect the front end, the word queue and the row generator.
// ----------------------------------------------------------------------------
package cdh_pkg;

	localparam int CELL_SIZE   = 16;
	localparam int PIX_W       = 8;
	localparam int ROW_W       = $clog2(CELL_SIZE);
	localparam int BAND_COUNT  = 11;
	localparam int GAIN_W      = 8;

	// Front end pipeline: band lookup, product, reciprocal multiply.
	localparam int PIPE_DEPTH  = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int USED_W      = $clog2(QUEUE_DEPTH + PIPE_DEPTH + 1);

	// ceil(x / 1000) is floor((x + 999) * RECIP_M >> RECIP_SHIFT); exact for
	// every product of an 8-bit pixel and an 8-bit gain.
	localparam int PROD_W      = 16;
	localparam int RECIP_W     = 17;
	localparam int MUL_W       = PROD_W + RECIP_W;
	localparam int RECIP_SHIFT = 26;
	localparam int QUOT_W      = MUL_W - RECIP_SHIFT;
	localparam int RECIP_M     = 67109;
	localparam int CEIL_BIAS   = 999;

	localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd255;
	localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(CELL_SIZE - 1);

	// Upper bounds of the dot-gain bands and their gains in thousandths.
	localparam logic [0:BAND_COUNT-1][PIX_W-1:0] BAND_LIMIT = '{
		8'd13, 8'd26, 8'd51, 8'd77, 8'd102, 8'd128, 8'd153, 8'd179, 8'd204, 8'd230, 8'd243
	};
	localparam logic [0:BAND_COUNT-1][GAIN_W-1:0] BAND_GAIN = '{
		8'd46, 8'd83, 8'd139, 8'd172, 8'd188, 8'd190, 8'd179, 8'd157, 8'd121, 8'd70, 8'd38
	};

	// Clustered-dot threshold ROM, indexed [row][column].
	localparam logic [0:CELL_SIZE-1][0:CELL_SIZE-1][PIX_W-1:0] THRESH_ROM = '{
		'{8'd0,   8'd4,   8'd12,  8'd24,  8'd40,  8'd60,  8'd84,  8'd112,
		  8'd113, 8'd85,  8'd61,  8'd41,  8'd25,  8'd13,  8'd5,   8'd1},
		'{8'd8,   8'd20,  8'd32,  8'd48,  8'd68,  8'd92,  8'd120, 8'd144,
		  8'd145, 8'd121, 8'd93,  8'd69,  8'd49,  8'd33,  8'd21,  8'd9},
		'{8'd16,  8'd36,  8'd56,  8'd76,  8'd100, 8'd128, 8'd152, 8'd172,
		  8'd173, 8'd153, 8'd129, 8'd101, 8'd77,  8'd57,  8'd37,  8'd17},
		'{8'd28,  8'd52,  8'd80,  8'd104, 8'd132, 8'd160, 8'd180, 8'd196,
		  8'd197, 8'd181, 8'd161, 8'd133, 8'd105, 8'd81,  8'd53,  8'd29},
		'{8'd44,  8'd72,  8'd108, 8'd136, 8'd164, 8'd188, 8'd204, 8'd216,
		  8'd217, 8'd205, 8'd189, 8'd165, 8'd137, 8'd109, 8'd73,  8'd45},
		'{8'd64,  8'd96,  8'd140, 8'd168, 8'd192, 8'd212, 8'd224, 8'd232,
		  8'd233, 8'd225, 8'd213, 8'd193, 8'd169, 8'd141, 8'd97,  8'd65},
		'{8'd88,  8'd124, 8'd156, 8'd184, 8'd208, 8'd228, 8'd240, 8'd244,
		  8'd245, 8'd241, 8'd229, 8'd209, 8'd185, 8'd157, 8'd125, 8'd89},
		'{8'd116, 8'd148, 8'd176, 8'd200, 8'd220, 8'd236, 8'd248, 8'd252,
		  8'd253, 8'd249, 8'd237, 8'd221, 8'd201, 8'd177, 8'd149, 8'd117},
		'{8'd119, 8'd151, 8'd179, 8'd203, 8'd223, 8'd239, 8'd251, 8'd255,
		  8'd254, 8'd250, 8'd238, 8'd222, 8'd202, 8'd178, 8'd150, 8'd118},
		'{8'd91,  8'd127, 8'd159, 8'd187, 8'd211, 8'd231, 8'd243, 8'd247,
		  8'd246, 8'd242, 8'd230, 8'd210, 8'd186, 8'd158, 8'd126, 8'd90},
		'{8'd67,  8'd99,  8'd143, 8'd171, 8'd195, 8'd215, 8'd227, 8'd235,
		  8'd234, 8'd226, 8'd214, 8'd194, 8'd170, 8'd142, 8'd98,  8'd66},
		'{8'd47,  8'd75,  8'd111, 8'd139, 8'd167, 8'd191, 8'd207, 8'd219,
		  8'd218, 8'd206, 8'd190, 8'd166, 8'd138, 8'd110, 8'd74,  8'd46},
		'{8'd31,  8'd55,  8'd83,  8'd107, 8'd135, 8'd163, 8'd183, 8'd199,
		  8'd198, 8'd182, 8'd162, 8'd134, 8'd106, 8'd82,  8'd54,  8'd30},
		'{8'd19,  8'd39,  8'd59,  8'd79,  8'd103, 8'd131, 8'd155, 8'd175,
		  8'd174, 8'd154, 8'd130, 8'd102, 8'd78,  8'd58,  8'd38,  8'd18},
		'{8'd11,  8'd23,  8'd35,  8'd51,  8'd71,  8'd95,  8'd123, 8'd147,
		  8'd146, 8'd122, 8'd94,  8'd70,  8'd50,  8'd34,  8'd22,  8'd10},
		'{8'd3,   8'd7,   8'd15,  8'd27,  8'd43,  8'd63,  8'd87,  8'd115,
		  8'd114, 8'd86,  8'd62,  8'd42,  8'd26,  8'd14,  8'd6,   8'd2}
	};

	// One corrected pixel word pushed into the queue.
	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] pixel;
	} qword_t;

	// Queue status seen by the front end and the row generator.
	typedef struct packed {
		logic              nonempty;
		logic [QLVL_W-1:0] level;
		logic [PIX_W-1:0]  head;
	} qstat_t;

	// Gain of the first band whose upper bound exceeds the pixel, 0 above all.
	function automatic logic [GAIN_W-1:0] band_gain(input logic [PIX_W-1:0] p);
		logic [GAIN_W-1:0] g;
		g = '0;
		for (int b = BAND_COUNT - 1; b >= 0; b--) begin
			if (p < BAND_LIMIT[b]) begin
				g = BAND_GAIN[b];
			end
		end
		return g;
	endfunction

endpackage

// ----- design/cdh_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halftone front end
// Accepts pixel words, applies the optional dot-gain compensation in a
// three-stage pipeline and pushes the corrected pixel into the queue.
// ----------------------------------------------------------------------------
module cdh_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [cdh_pkg::PIX_W-1:0] pixel,
	input  cdh_pkg::qstat_t          qstat,
	output cdh_pkg::qword_t          push
);
	import cdh_pkg::*;

	logic              tone_q;
	logic              v_s1, v_s2, v_s3;
	logic [PIX_W-1:0]  pix_s1, pix_s2, pix_s3;
	logic [GAIN_W-1:0] gain_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [MUL_W-1:0]  scaled_s3;
	logic [MUL_W-1:0]  biased;
	logic [QUOT_W-1:0] cut;
	logic [USED_W-1:0] used;
	logic              accept;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q <= 1'b0;
		end else if (cfg_we) begin
			tone_q <= cfg_wdata;
		end
	end

	// Credit check: queue entries plus words in flight must leave a free slot.
	assign used = USED_W'(qstat.level) + USED_W'(v_s1) + USED_W'(v_s2) + USED_W'(v_s3);
	assign in_stall = (used >= USED_W'(QUEUE_DEPTH));
	assign accept = in_valid && !in_stall;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// A zero gain leaves the pixel unchanged: the bias alone divides to zero.
	assign biased = MUL_W'(prod_s2) + MUL_W'(CEIL_BIAS);

	// Datapath: band lookup, product, reciprocal multiply.
	always_ff @(posedge clk) begin
		pix_s1    <= pixel;
		gain_s1   <= tone_q ? band_gain(pixel) : '0;
		pix_s2    <= pix_s1;
		prod_s2   <= PROD_W'(pix_s1 * gain_s1);
		pix_s3    <= pix_s2;
		scaled_s3 <= MUL_W'(biased * MUL_W'(RECIP_M));
	end

	// The rounded-up cut never exceeds the pixel, so no clamp is needed.
	assign cut = scaled_s3[MUL_W-1:RECIP_SHIFT];
	assign push.valid = v_s3;
	assign push.pixel = pix_s3 - PIX_W'(cut);

endmodule

// ----- design/cdh_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halftone word queue
// A short first-in first-out queue of corrected pixels between the front end
// and the row generator. The front end never pushes into a full queue.
// ----------------------------------------------------------------------------
module cdh_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  cdh_pkg::qword_t push,
	input  logic            pop,
	output cdh_pkg::qstat_t qstat
);
	import cdh_pkg::*;

	logic [PIX_W-1:0]  entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0] level_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push.valid) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.pixel;
		end
	end

	assign qstat.nonempty = (level_q != '0);
	assign qstat.level    = level_q;
	assign qstat.head     = entry_q[rd_ptr_q];

endmodule

// ----- design/cdh_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halftone row generator
// Takes corrected pixels from the queue and emits the sixteen rows of each
// cell through an output register, one row word per cycle unless stalled.
// ----------------------------------------------------------------------------
module cdh_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cdh_pkg::qstat_t               qstat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cdh_pkg::ROW_W-1:0]     row_index,
	output logic [cdh_pkg::CELL_SIZE-1:0] row_bits,
	output logic                          last_row
);
	import cdh_pkg::*;

	logic                 active_q;
	logic [PIX_W-1:0]     pix_q;
	logic [ROW_W-1:0]     row_q;
	logic                 out_valid_q;
	logic [ROW_W-1:0]     row_index_q;
	logic [CELL_SIZE-1:0] row_bits_q;
	logic                 last_row_q;
	logic                 advance;
	logic                 at_last;
	logic [CELL_SIZE-1:0] bits;

	// The output register can load when it is empty or being taken.
	assign advance = !out_valid_q || !out_stall;
	assign at_last = (row_q == ROW_LAST);

	// Take a new pixel when idle, or as the last row of a cell is loaded into the output register.
	assign pop = qstat.nonempty && (!active_q || (advance && at_last));

	// Threshold compare for the current row.
	always_comb begin
		for (int c = 0; c < CELL_SIZE; c++) begin
			bits[c] = (pix_q == WHITE_LEVEL) || (THRESH_ROM[row_q][c] < pix_q);
		end
	end

	// Cell sequencing control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!active_q) begin
				if (qstat.nonempty) begin
					active_q <= 1'b1;
					row_q    <= '0;
				end
			end else if (advance) begin
				if (at_last) begin
					active_q <= qstat.nonempty;
					row_q    <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= active_q;
			end
		end
	end

	// Pixel and output word registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			pix_q <= qstat.head;
		end
		if (advance) begin
			row_index_q <= row_q;
			row_bits_q  <= bits;
			last_row_q  <= at_last;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign row_bits  = row_bits_q;
	assign last_row  = last_row_q;

endmodule

// ----- design/clustered_dot_halftone_cell_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clustered-dot halftone cell unit
// Each accepted pixel word becomes one 16x16 clustered-dot cell, delivered as
// sixteen row words, top row first, one row word per cycle while out_stall is
// low; the sustained pixel rate is set by the row generator and its output
// register. A pixel passes through the three front-end stages, the queue,
// the row generator's pixel register and the output register before its
// first row appears; the front end keeps taking pixels until four of them
// wait in its pipeline and the four-entry queue together.
// ----------------------------------------------------------------------------
module clustered_dot_halftone_cell_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cdh_pkg::PIX_W-1:0]     pixel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cdh_pkg::ROW_W-1:0]     row_index,
	output logic [cdh_pkg::CELL_SIZE-1:0] row_bits,
	output logic                          last_row
);
	import cdh_pkg::*;

	qword_t push;
	qstat_t qstat;
	logic   pop;

	// Compensation front end.
	cdh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.qstat     (qstat),
		.push      (push)
	);

	// Queue of corrected pixels.
	cdh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat)
	);

	// Row generator.
	cdh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row_index (row_index),
		.row_bits  (row_bits),
		.last_row  (last_row)
	);

endmodule

// ----- design/cdh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halftone cell unit checker
// Port-level assertions on the row word stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "clustered_dot_halftone_cell_unit_macros.svh"

module cdh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [cdh_pkg::ROW_W-1:0]     row_index,
	input logic [cdh_pkg::CELL_SIZE-1:0] row_bits,
	input logic                          last_row
);
	import cdh_pkg::*;

	logic                       out_held;
	logic                       mid_take;
	logic                       end_take;
	logic [ROW_W-1:0]           row_inc;
	logic [ROW_W+CELL_SIZE:0]   out_word;

	// Handshake events and the whole row word.
	assign out_held = out_valid && out_stall;
	assign mid_take = out_valid && !out_stall && !last_row;
	assign end_take = out_valid && !out_stall && last_row;
	assign row_inc  = row_index + 1'b1;
	assign out_word = {row_index, row_bits, last_row};

	// A stalled row word stays valid and unchanged.
	`CDH_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "held word changed")

	// The last-row flag marks exactly the bottom row of a cell.
	`CDH_ASSERT_NOW(a_last_flag, out_valid, last_row == (row_index == ROW_LAST), "bad last_row")

	// After a row that is not the last, the next word carries the next row.
	`CDH_ASSERT_NEXT(a_row_step, mid_take, !out_valid || row_index == $past(row_inc), "row skipped")

	// After the last row, the next word starts a new cell at the top row.
	`CDH_ASSERT_NEXT(a_cell_start, end_take, !out_valid || row_index == '0, "cell not at top row")

endmodule

bind clustered_dot_halftone_cell_unit cdh_checker u_cdh_checker (.*);
